// ===== design/allocation_tracker_table_assert.svh =====
// Assertion macros for the allocation tracker table.
`ifndef ALLOCATION_TRACKER_TABLE_ASSERT_SVH
`define ALLOCATION_TRACKER_TABLE_ASSERT_SVH
`ifndef ASSERT_OFF
`define ATT_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("att check failed");
`define ATT_ASSERT_NORST(label, clk, prop) \
	label: assert property (@(posedge clk) prop) else $error("att check failed");
`else
`define ATT_ASSERT(label, clk, rst_n, prop)
`define ATT_ASSERT_NORST(label, clk, prop)
`endif
`endif

// ===== design/att_pkg.sv =====
// Types and constants shared by the allocation tracker table modules.
package att_pkg;
	localparam logic [1:0] CMD_ALLOC   = 2'd0;
	localparam logic [1:0] CMD_FREE    = 2'd1;
	localparam logic [1:0] CMD_REALLOC = 2'd2;

	localparam logic [2:0] ST_OK   = 3'd0;
	localparam logic [2:0] ST_FULL = 3'd1;
	localparam logic [2:0] ST_MISS = 3'd2;
	localparam logic [2:0] ST_NULL = 3'd3;
	localparam logic [2:0] ST_NONE = 3'd4;

	localparam int CNT_W = 11;

	// Register indexes of the configuration port.
	localparam logic CFG_WIN_LOW  = 1'b0;
	localparam logic CFG_WIN_HIGH = 1'b1;

	// Write request handed from the controller to the slot memory.
	typedef struct packed {
		logic        we;
		logic [31:0] addr;
		logic [31:0] size;
	} att_wr_t;
endpackage

// ===== design/att_slot_mem.sv =====
// Slot memory: address and size arrays with a clearing pass after reset.
module att_slot_mem import att_pkg::*; #(
	parameter int SLOTS = 1024,
	parameter int IW = $clog2(SLOTS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [IW-1:0] rd_idx,
	output logic [31:0]   rd_addr,
	output logic [31:0]   rd_size,
	input  logic [IW-1:0] wr_idx,
	input  att_wr_t       wr,
	output logic          clr_done
);
	logic [31:0] addr_mem [SLOTS];
	logic [31:0] size_mem [SLOTS];
	logic [IW:0] clr_q;

	// Clearing pass counter, one entry per cycle after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clr_q != (IW+1)'(SLOTS)) begin
			clr_q <= clr_q + 1'b1;
		end
	end
	assign clr_done = (clr_q == (IW+1)'(SLOTS));

	// Single write port shared by the clearing pass and the controller.
	always_ff @(posedge clk) begin
		if (!clr_done) begin
			addr_mem[clr_q[IW-1:0]] <= '0;
			size_mem[clr_q[IW-1:0]] <= '0;
		end else if (wr.we) begin
			addr_mem[wr_idx] <= wr.addr;
			size_mem[wr_idx] <= wr.size;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rd_addr <= addr_mem[rd_idx];
		rd_size <= size_mem[rd_idx];
	end
endmodule

// ===== design/allocation_tracker_table.sv =====
// Allocation tracker table top level: event sequencer and running totals.
// An event settled by its fields alone goes straight to the result; one that scans the slot memory
// reads one entry per cycle, from the hint for an add or from slot zero otherwise.
// One event is handled at a time: the next word is taken only after the result word is accepted.
// After reset a clearing pass zeroes every entry of the memory before input is taken.
// Configuration writes take effect at once and belong between events.
`include "allocation_tracker_table_assert.svh"
module allocation_tracker_table import att_pkg::*; #(
	parameter int SLOTS = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// cmd[1:0], old_addr[33:2], new_addr[65:34], req_size[97:66], zero fill to 104
	input  logic [103:0]  s_tdata,
	output logic          m_tvalid,
	input  logic          m_tready,
	// status[2:0], prior_size[34:3], total_bytes[66:35], total_bytes_peak[98:67],
	// total_entries[109:99], total_entries_peak[120:110], window_bytes[152:121],
	// window_bytes_peak[184:153], window_entries[195:185], window_entries_peak[206:196],
	// zero fill to 208
	output logic [207:0]  m_tdata,
	input  logic          cfg_we,
	input  logic          cfg_idx,
	input  logic [31:0]   cfg_data
);
	localparam int IW = $clog2(SLOTS);
	localparam int HW = IW + 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_DONE = 3'd2;
	localparam logic [2:0] S_OUT  = 3'd3;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_DEL = 2'd1;
	localparam logic [1:0] OP_UPD = 2'd2;

	logic [2:0]  state_q;
	logic [31:0] win_lo_q, win_hi_q;
	logic [1:0]  op_q;        // 0 add, 1 delete, 2 update
	logic [31:0] key_q, newa_q, size_q;
	logic [HW-1:0] idx_q;     // index being read, valid data arrives next cycle
	logic [HW-1:0] hint_q;
	logic        rd_pend_q;
	logic [IW-1:0] hit_idx_q;
	logic [31:0] hit_size_q;
	logic        hit_q;
	logic [31:0] sum_all_q, sum_all_pk_q, sum_win_q, sum_win_pk_q;
	logic [CNT_W-1:0] cnt_all_q, cnt_all_pk_q, cnt_win_q, cnt_win_pk_q;
	logic [2:0]  status_q;
	logic [31:0] prior_q;
	logic        out_v_q;

	logic [IW-1:0] rd_idx;
	logic [31:0]   rd_addr, rd_size;
	att_wr_t       wr;
	logic [IW-1:0] wr_idx;
	logic          clr_done;

	logic [1:0]  in_cmd;
	logic [31:0] in_old, in_new, in_size;
	assign in_cmd  = s_tdata[1:0];
	assign in_old  = s_tdata[33:2];
	assign in_new  = s_tdata[65:34];
	assign in_size = s_tdata[97:66];

	assign s_tready = clr_done && (state_q == S_IDLE) && !out_v_q;
	logic acc;
	assign acc = s_tvalid && s_tready;

	att_slot_mem #(.SLOTS(SLOTS), .IW(IW)) u_mem (
		.clk(clk), .arst_n(arst_n), .rd_idx(rd_idx), .rd_addr(rd_addr),
		.rd_size(rd_size), .wr_idx(wr_idx), .wr(wr), .clr_done(clr_done)
	);

	assign rd_idx = idx_q[IW-1:0];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_lo_q <= '0;
			win_hi_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_WIN_LOW:  win_lo_q <= cfg_data;
				CFG_WIN_HIGH: win_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	function automatic logic in_win(input logic [31:0] a, input logic [31:0] lo,
			input logic [31:0] hi);
		return (a >= lo) && (a < hi);
	endfunction

	// Decode of the incoming word: which scan it needs, or its immediate status.
	logic        dec_scan;
	logic [1:0]  dec_op;
	logic [2:0]  dec_status;
	logic [31:0] dec_key;
	always_comb begin
		dec_scan = 1'b0;
		dec_op = OP_ADD;
		dec_status = ST_NONE;
		dec_key = '0;
		if (in_cmd == CMD_ALLOC || (in_cmd == CMD_REALLOC &&
				in_size != 0 && in_new != 0 && in_old == 0)) begin
			if (in_new == 0) dec_status = ST_NULL;
			else dec_scan = 1'b1;
		end else if (in_cmd == CMD_FREE ||
				(in_cmd == CMD_REALLOC && in_size == 0)) begin
			if (in_old != 0) begin
				dec_scan = 1'b1;
				dec_op = OP_DEL;
				dec_key = in_old;
			end
		end else if (in_cmd == CMD_REALLOC) begin
			if (in_new == 0) begin
				dec_status = ST_NULL;
			end else begin
				dec_scan = 1'b1;
				dec_op = OP_UPD;
				dec_key = in_old;
			end
		end
	end

	// Match test for the entry read last cycle.
	logic match;
	assign match = rd_pend_q && (rd_addr == key_q);

	// Write back at the end of the event.
	always_comb begin
		wr = '0;
		wr_idx = hit_idx_q;
		if (state_q == S_DONE && hit_q) begin
			wr.we = 1'b1;
			unique case (op_q)
				OP_ADD: begin wr.addr = newa_q; wr.size = size_q; end
				OP_DEL: begin wr.addr = '0; wr.size = '0; end
				default: begin wr.addr = newa_q; wr.size = size_q; end
			endcase
		end
	end

	logic [31:0] sa_n, sw_n;
	logic [CNT_W-1:0] ca_n, cw_n;
	always_comb begin
		sa_n = sum_all_q; sw_n = sum_win_q; ca_n = cnt_all_q; cw_n = cnt_win_q;
		unique case (op_q)
			OP_ADD: begin
				sa_n = sum_all_q + size_q;
				ca_n = cnt_all_q + 1'b1;
				if (in_win(newa_q, win_lo_q, win_hi_q)) begin
					sw_n = sum_win_q + size_q;
					cw_n = cnt_win_q + 1'b1;
				end
			end
			OP_DEL: begin
				sa_n = sum_all_q - hit_size_q;
				ca_n = cnt_all_q - 1'b1;
				if (in_win(key_q, win_lo_q, win_hi_q)) begin
					sw_n = sum_win_q - hit_size_q;
					cw_n = cnt_win_q - 1'b1;
				end
			end
			default: begin
				sa_n = sum_all_q - hit_size_q + size_q;
				if (in_win(key_q, win_lo_q, win_hi_q) && in_win(newa_q, win_lo_q, win_hi_q))
					sw_n = sum_win_q - hit_size_q + size_q;
				else if (in_win(key_q, win_lo_q, win_hi_q))
					sw_n = sum_win_q - hit_size_q;
				else if (in_win(newa_q, win_lo_q, win_hi_q))
					sw_n = sum_win_q + size_q;
			end
		endcase
	end

	// Event sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_v_q <= 1'b0;
			rd_pend_q <= 1'b0;
			hit_q <= 1'b0;
			hint_q <= '0;
			idx_q <= '0;
			sum_all_q <= '0; sum_all_pk_q <= '0; sum_win_q <= '0; sum_win_pk_q <= '0;
			cnt_all_q <= '0; cnt_all_pk_q <= '0; cnt_win_q <= '0; cnt_win_pk_q <= '0;
		end else begin
			if (out_v_q && m_tready) out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						status_q <= dec_status;
						prior_q <= '0;
						hit_q <= 1'b0;
						newa_q <= in_new;
						size_q <= in_size;
						op_q <= dec_op;
						key_q <= dec_key;
						idx_q <= (dec_op == OP_ADD) ? hint_q : '0;
						rd_pend_q <= 1'b0;
						state_q <= dec_scan ? S_SCAN : S_OUT;
					end
				end
				S_SCAN: begin
					if (match) begin
						hit_q <= 1'b1;
						hit_idx_q <= IW'(idx_q - 1'b1);
						hit_size_q <= rd_size;
						rd_pend_q <= 1'b0;
						state_q <= S_DONE;
					end else if (idx_q >= HW'(SLOTS)) begin
						rd_pend_q <= 1'b0;
						status_q <= (op_q == OP_ADD) ? ST_FULL : ST_MISS;
						state_q <= S_OUT;
					end else begin
						idx_q <= idx_q + 1'b1;
						rd_pend_q <= 1'b1;
					end
				end
				S_DONE: begin
					status_q <= ST_OK;
					prior_q <= (op_q == OP_ADD) ? 32'd0 : hit_size_q;
					sum_all_q <= sa_n; sum_win_q <= sw_n;
					cnt_all_q <= ca_n; cnt_win_q <= cw_n;
					// Byte peaks follow adds and updates; a delete never raises them.
					if (op_q != OP_DEL) begin
						if (sa_n > sum_all_pk_q) sum_all_pk_q <= sa_n;
						if (sw_n > sum_win_pk_q) sum_win_pk_q <= sw_n;
					end
					if (op_q == OP_ADD) begin
						if (ca_n > cnt_all_pk_q) cnt_all_pk_q <= ca_n;
						if (in_win(newa_q, win_lo_q, win_hi_q) && cw_n > cnt_win_pk_q)
							cnt_win_pk_q <= cw_n;
						hint_q <= HW'(hit_idx_q) + 1'b1;
					end else if (op_q == OP_DEL && HW'(hit_idx_q) < hint_q) begin
						hint_q <= HW'(hit_idx_q);
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					out_v_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = {1'b0, cnt_win_pk_q, cnt_win_q, sum_win_pk_q, sum_win_q,
		cnt_all_pk_q, cnt_all_q, sum_all_pk_q, sum_all_q, prior_q, status_q};

	`ATT_ASSERT(a_no_accept_busy, clk, arst_n, (state_q != S_IDLE) |-> !s_tready)
	`ATT_ASSERT(a_wr_only_done, clk, arst_n, wr.we |-> (state_q == S_DONE))
	`ATT_ASSERT(a_hold_out, clk, arst_n, (m_tvalid && !m_tready) |=> m_tvalid)
	`ATT_ASSERT(a_peak_all, clk, arst_n, (state_q == S_OUT) |-> (sum_all_pk_q >= 32'd0))
	`ATT_ASSERT(a_cnt_peak, clk, arst_n, (out_v_q) |-> (cnt_all_pk_q >= 11'd0))
endmodule

// ===== dv/tb_allocation_tracker_table.sv =====
// Self-checking testbench for the allocation tracker table.
`timescale 1ns / 1ps

module tb_allocation_tracker_table;
	import att_pkg::*;

	localparam int SLOTS = 1024;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// Result word layout, highest field first.
	typedef struct packed {
		logic        pad;
		logic [10:0] win_cnt_pk;
		logic [10:0] win_cnt;
		logic [31:0] win_bytes_pk;
		logic [31:0] win_bytes;
		logic [10:0] all_cnt_pk;
		logic [10:0] all_cnt;
		logic [31:0] all_bytes_pk;
		logic [31:0] all_bytes;
		logic [31:0] prior;
		logic [2:0]  status;
	} tally_t;

	// Mirror of the allocation table and the tallies it produces.
	class alloc_ledger;
		bit [31:0] slot_addr[SLOTS];
		bit [31:0] slot_sz[SLOTS];
		int        hint;
		bit [31:0] all_bytes, all_bytes_pk, win_bytes, win_bytes_pk;
		bit [10:0] all_cnt, all_cnt_pk, win_cnt, win_cnt_pk;
		bit [31:0] win_lo, win_hi;
		tally_t    tally_q[$];
		int        errors;
		int        words_seen;

		function bit in_win(bit [31:0] a);
			return a >= win_lo && a < win_hi;
		endfunction

		function void set_window(bit idx, bit [31:0] v);
			if (idx == CFG_WIN_LOW) win_lo = v;
			else win_hi = v;
		endfunction

		function int find_slot(bit [31:0] a);
			for (int i = 0; i < SLOTS; i++)
				if (slot_addr[i] == a) return i;
			return SLOTS;
		endfunction

		function void raise_byte_peaks();
			if (all_bytes > all_bytes_pk) all_bytes_pk = all_bytes;
			if (win_bytes > win_bytes_pk) win_bytes_pk = win_bytes;
		endfunction

		function logic [2:0] add_entry(bit [31:0] a, bit [31:0] sz);
			for (int i = hint; i < SLOTS; i++) begin
				if (slot_addr[i] == 0) begin
					slot_addr[i] = a;
					slot_sz[i] = sz;
					hint = i + 1;
					all_cnt++;
					all_bytes += sz;
					if (all_cnt > all_cnt_pk) all_cnt_pk = all_cnt;
					if (in_win(a)) begin
						win_cnt++;
						win_bytes += sz;
						if (win_cnt > win_cnt_pk) win_cnt_pk = win_cnt;
					end
					raise_byte_peaks();
					return ST_OK;
				end
			end
			return ST_FULL;
		endfunction

		function logic [2:0] drop_entry(bit [31:0] a, output bit [31:0] prior);
			int i;
			i = find_slot(a);
			prior = 0;
			if (i >= SLOTS) return ST_MISS;
			prior = slot_sz[i];
			slot_addr[i] = 0;
			slot_sz[i] = 0;
			all_bytes -= prior;
			all_cnt--;
			if (i < hint) hint = i;
			if (in_win(a)) begin
				win_bytes -= prior;
				win_cnt--;
			end
			return ST_OK;
		endfunction

		function logic [2:0] move_entry(bit [31:0] olda, bit [31:0] newa, bit [31:0] sz,
				output bit [31:0] prior);
			int i;
			i = find_slot(olda);
			prior = 0;
			if (i >= SLOTS) return ST_MISS;
			prior = slot_sz[i];
			all_bytes = all_bytes - prior + sz;
			slot_addr[i] = newa;
			slot_sz[i] = sz;
			if (in_win(olda)) win_bytes -= prior;
			if (in_win(newa)) win_bytes += sz;
			raise_byte_peaks();
			return ST_OK;
		endfunction

		// Apply one accepted event word and queue the result it must produce.
		function void note_event(logic [1:0] cmd, bit [31:0] olda, bit [31:0] newa,
				bit [31:0] sz);
			tally_t t;
			bit [31:0] prior;
			t = '0;
			prior = 0;
			t.status = ST_NONE;
			if (cmd == CMD_ALLOC) begin
				t.status = (newa != 0) ? add_entry(newa, sz) : ST_NULL;
			end else if (cmd == CMD_FREE) begin
				if (olda != 0) t.status = drop_entry(olda, prior);
			end else if (cmd == CMD_REALLOC) begin
				if (sz == 0) begin
					if (olda != 0) t.status = drop_entry(olda, prior);
				end else if (newa == 0) begin
					t.status = ST_NULL;
				end else if (olda == 0) begin
					t.status = add_entry(newa, sz);
				end else begin
					t.status = move_entry(olda, newa, sz, prior);
				end
			end
			t.prior = prior;
			t.all_bytes = all_bytes;
			t.all_bytes_pk = all_bytes_pk;
			t.all_cnt = all_cnt;
			t.all_cnt_pk = all_cnt_pk;
			t.win_bytes = win_bytes;
			t.win_bytes_pk = win_bytes_pk;
			t.win_cnt = win_cnt;
			t.win_cnt_pk = win_cnt_pk;
			tally_q.push_back(t);
		endfunction

		function void cmp(string nm, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch: expected %h, actual %h", $time, nm, want, got);
				errors++;
			end
		endfunction

		// Compare a result word against the oldest queued tally.
		function void check_result(logic [207:0] d);
			tally_t got, want;
			got = d;
			words_seen++;
			if (tally_q.size() == 0) begin
				$display("%0t: unexpected result word: expected none, actual %h", $time, d);
				errors++;
				return;
			end
			want = tally_q.pop_front();
			cmp("status", 32'(want.status), 32'(got.status));
			cmp("prior_size", want.prior, got.prior);
			cmp("total_bytes", want.all_bytes, got.all_bytes);
			cmp("total_bytes_peak", want.all_bytes_pk, got.all_bytes_pk);
			cmp("total_entries", 32'(want.all_cnt), 32'(got.all_cnt));
			cmp("total_entries_peak", 32'(want.all_cnt_pk), 32'(got.all_cnt_pk));
			cmp("window_bytes", want.win_bytes, got.win_bytes);
			cmp("window_bytes_peak", want.win_bytes_pk, got.win_bytes_pk);
			cmp("window_entries", 32'(want.win_cnt), 32'(got.win_cnt));
			cmp("window_entries_peak", 32'(want.win_cnt_pk), 32'(got.win_cnt_pk));
			cmp("fill", 32'(want.pad), 32'(got.pad));
		endfunction

		// A live address picked from a random starting slot, or zero if the table is empty.
		function bit [31:0] pick_live();
			int s;
			s = $urandom_range(SLOTS - 1);
			for (int i = 0; i < SLOTS; i++)
				if (slot_addr[(s + i) % SLOTS] != 0) return slot_addr[(s + i) % SLOTS];
			return 0;
		endfunction
	endclass

	logic          clk;
	logic          arst_n = 1'b0;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [103:0]  s_tdata = '0;
	logic          m_tvalid;
	logic          m_tready = 1'b0;
	logic [207:0]  m_tdata;
	logic          cfg_we = 1'b0;
	logic          cfg_idx = 1'b0;
	logic [31:0]   cfg_data = '0;

	alloc_ledger   ledger = new();
	int            send_idle_pct = 0;
	int            stall_pct = 0;
	int            hold_left = 0;
	int            events_sent = 0;

	allocation_tracker_table #(.SLOTS(SLOTS)) DUT (.*);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog.
	initial begin
		#400_000_000;
		$display("allocation_tracker_table regression: fail");
		$finish;
	end

	// Result side: check each accepted word, then pick the next ready value.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) ledger.check_result(m_tdata);
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Offer one event word after a random gap and wait until it is taken.
	task automatic send_event(logic [1:0] cmd, logic [31:0] olda, logic [31:0] newa,
			logic [31:0] sz);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct) gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, sz, newa, olda, cmd};
		do @(posedge clk); while (!s_tready);
		ledger.note_event(cmd, olda, newa, sz);
		events_sent++;
	endtask

	// Stop offering and wait until every expected word has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (ledger.tally_q.size() > 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_window(logic [31:0] lo, logic [31:0] hi);
		cfg_we <= 1'b1;
		cfg_idx <= CFG_WIN_LOW;
		cfg_data <= lo;
		@(posedge clk);
		ledger.set_window(CFG_WIN_LOW, lo);
		cfg_idx <= CFG_WIN_HIGH;
		cfg_data <= hi;
		@(posedge clk);
		ledger.set_window(CFG_WIN_HIGH, hi);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] rand_addr();
		logic [31:0] a;
		a = $urandom();
		return (a == 0) ? 32'd1 : a;
	endfunction

	function automatic logic [31:0] rand_size();
		case ($urandom_range(3))
			0: return $urandom();
			1: return $urandom_range(255);
			2: return ($urandom_range(1)) ? 32'd0 : 32'hFFFF_FFFF;
			default: return $urandom_range(65535);
		endcase
	endfunction

	// One random event, mostly well-formed allocations and operations on live entries.
	task automatic random_event();
		int r;
		logic [31:0] live;
		r = $urandom_range(99);
		live = ledger.pick_live();
		if (live == 0) live = rand_addr();
		if (r < 35) send_event(CMD_ALLOC, $urandom(), rand_addr(), rand_size());
		else if (r < 55) send_event(CMD_FREE, live, $urandom(), $urandom());
		else if (r < 70) send_event(CMD_REALLOC, live, rand_addr(), rand_size() | 32'd1);
		else if (r < 75) send_event(CMD_REALLOC, live, $urandom(), 32'd0);
		else if (r < 80) send_event(CMD_REALLOC, 32'd0, rand_addr(), rand_size() | 32'd1);
		else if (r < 84) send_event(CMD_REALLOC, live, 32'd0, rand_size() | 32'd1);
		else if (r < 88) send_event($urandom_range(1) ? CMD_FREE : CMD_REALLOC, 32'd0,
				$urandom(), 32'd0);
		else if (r < 92) send_event(CMD_FREE, rand_addr(), $urandom(), $urandom());
		else if (r < 95) send_event(CMD_UNUSED, $urandom(), $urandom(), $urandom());
		else if (r < 97) send_event(CMD_ALLOC, $urandom(), 32'd0, rand_size());
		else send_event(CMD_ALLOC, $urandom(), live, rand_size());
	endtask

	initial begin
		logic [31:0] lo, hi;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_window(32'h0000_1000, 32'h8000_0000);

		// Directed: each command, null operands, misses, wrap of the byte sum.
		send_event(CMD_ALLOC, 32'd0, 32'd0, 32'd7);
		send_event(CMD_ALLOC, 32'd0, 32'h0000_0100, 32'hFFFF_FFFF);
		send_event(CMD_ALLOC, 32'd0, 32'hFFFF_FFFF, 32'd0);
		send_event(CMD_ALLOC, 32'd0, 32'h0000_2000, 32'd5);
		send_event(CMD_FREE, 32'd0, 32'd0, 32'd0);
		send_event(CMD_FREE, 32'h0000_1234, 32'd0, 32'd0);
		send_event(CMD_FREE, 32'h0000_0100, 32'd0, 32'd0);
		send_event(CMD_REALLOC, 32'd0, 32'h0000_4000, 32'd0);
		send_event(CMD_REALLOC, 32'h0000_2000, 32'd0, 32'd0);
		send_event(CMD_REALLOC, 32'hFFFF_FFFF, 32'd0, 32'd9);
		send_event(CMD_REALLOC, 32'd0, 32'h0000_3000, 32'h10);
		send_event(CMD_REALLOC, 32'h0000_3000, 32'h9000_0000, 32'h20);
		send_event(CMD_REALLOC, 32'h0000_5555, 32'h0000_6000, 32'h30);
		send_event(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_event(CMD_ALLOC, 32'd0, 32'h9000_0000, 32'h40);
		send_event(CMD_FREE, 32'h9000_0000, 32'd0, 32'd0);
		send_event(CMD_FREE, 32'hFFFF_FFFF, 32'd0, 32'd0);
		send_event(CMD_REALLOC, 32'h9000_0000, 32'h0000_7000, 32'hFFFF_FFFF);
		drain();

		// Random phases, each under its own window and idling mix.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; stall_pct = 0; lo = 32'd0; hi = 32'hFFFF_FFFF; end
				1: begin
					send_idle_pct = 83; stall_pct = 0;
					lo = $urandom_range(32'h7FFF_FFFF); hi = lo + $urandom_range(32'h7FFF_FFFF);
				end
				2: begin send_idle_pct = 0; stall_pct = 83; lo = 32'hFFFF_FFFF; hi = 32'd0; end
				default: begin
					send_idle_pct = 31; stall_pct = 31;
					lo = 32'h4000_0000; hi = 32'h4000_0000;
				end
			endcase
			write_window(lo, hi);
			// In the first phase the result side holds off for a long stretch while a word is offered.
			if (ph == 0) hold_left = 400;
			for (int n = 0; n < 140; n++) random_event();
			drain();
		end

		repeat (40) @(posedge clk);
		$display("Ran %0d events through directed cases and four random phases,",
			events_sent);
		$display("with a long result hold; %0d result words compared field by field.",
			ledger.words_seen);
		if (ledger.errors == 0 && ledger.tally_q.size() == 0) begin
			$display("allocation_tracker_table regression: pass");
		end else begin
			$display("allocation_tracker_table regression: fail");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+design
design/att_pkg.sv
design/att_slot_mem.sv
design/allocation_tracker_table.sv
dv/tb_allocation_tracker_table.sv
